/* design/rwpf_pkg.sv */
package rwpf_pkg;

  // Default for the largest element the reversal buffer holds.
  localparam int MAX_ELEMENT_BYTES_DEF = 8;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDING_BYTE = 2'd1;

  // Input item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // Source of the next transmitted byte.
  localparam logic [2:0] SEL_HEADER  = 3'd0;
  localparam logic [2:0] SEL_ADDR    = 3'd1;
  localparam logic [2:0] SEL_COUNT   = 3'd2;
  localparam logic [2:0] SEL_SIZE    = 3'd3;
  localparam logic [2:0] SEL_PAYLOAD = 3'd4;
  localparam logic [2:0] SEL_ENDING  = 3'd5;

  // One input request.
  typedef struct packed {
    logic       mode;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] element_size;
    logic [7:0] data_byte;
  } in_t;

  // One transmitted byte with its flags.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       end_of_run;
    logic       end_of_packet;
    logic       size_error;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_start;
    logic       store_byte;
    logic       emit;
    logic [2:0] sel;
    logic       last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pkt_open;
    logic elem_full;
    logic rd_zero;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/rwpf_ctrl.sv */
module rwpf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_mode_i,
  output logic                 in_ready_o,
  input  rwpf_pkg::dp_stat_t   stat_i,
  output rwpf_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_PAY  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] step_q, step_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = rwpf_pkg::SEL_HEADER;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == rwpf_pkg::MODE_START) begin
            cmd_o.load_start = 1'b1;
            step_d           = 2'd0;
            state_d          = S_HDR;
          end else if (stat_i.pkt_open) begin
            cmd_o.store_byte = 1'b1;
            if (stat_i.elem_full) begin
              state_d = S_PAY;
            end
          end
        end
      end
      S_HDR: begin
        case (step_q)
          2'd0:    cmd_o.sel = rwpf_pkg::SEL_HEADER;
          2'd1:    cmd_o.sel = rwpf_pkg::SEL_ADDR;
          2'd2:    cmd_o.sel = rwpf_pkg::SEL_COUNT;
          default: cmd_o.sel = rwpf_pkg::SEL_SIZE;
        endcase
        // The size byte ends the run only when no ending byte follows at once.
        cmd_o.last = (step_q == 2'd3) && stat_i.pkt_open;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          step_d     = step_q + 2'd1;
          if (step_q == 2'd3) begin
            state_d = stat_i.pkt_open ? S_IDLE : S_END;
          end
        end
      end
      S_PAY: begin
        cmd_o.sel  = rwpf_pkg::SEL_PAYLOAD;
        cmd_o.last = stat_i.rd_zero && stat_i.pkt_open;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.rd_zero) begin
            state_d = stat_i.pkt_open ? S_IDLE : S_END;
          end
        end
      end
      S_END: begin
        cmd_o.sel  = rwpf_pkg::SEL_ENDING;
        cmd_o.last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // The ending byte is only sent once the packet has been closed.
  a_end_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_END |-> !stat_i.pkt_open)
    else $error("ending byte pending while packet still open");

  // The output register is never overwritten while a byte waits in it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("byte emitted into an occupied output register");

endmodule

/* design/rwpf_datapath.sv */
module rwpf_datapath #(
  parameter int MAX_ELEMENT_BYTES = rwpf_pkg::MAX_ELEMENT_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rwpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                       cfg_data_i,
  input  rwpf_pkg::in_t                    in_data_i,
  input  rwpf_pkg::ctrl_cmd_t              cmd_i,
  output rwpf_pkg::dp_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rwpf_pkg::out_t                   out_data_o
);

  localparam int IW = (MAX_ELEMENT_BYTES > 1) ? $clog2(MAX_ELEMENT_BYTES) : 1;
  localparam int SW = $clog2(MAX_ELEMENT_BYTES + 1);

  logic [7:0]    header_q, ending_q;
  logic [7:0]    addr_q, count_q, size_q;
  logic          err_q;
  logic          open_q, open_d;
  logic [SW-1:0] asize_q, asize_d;
  logic [IW-1:0] bidx_q, bidx_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [7:0]    left_q, left_d;
  logic [7:0]    buffer_q [MAX_ELEMENT_BYTES];
  logic          out_valid_q;
  rwpf_pkg::out_t out_q;

  logic          start_bad;
  logic          elem_full;
  logic          out_free;
  logic [7:0]    left_sub;

  // Size check and element bookkeeping.
  assign start_bad = (in_data_i.element_size == 8'd0) ||
                     (in_data_i.element_size > 8'(MAX_ELEMENT_BYTES));
  assign elem_full = (SW'(bidx_q) + SW'(1)) == asize_q;
  assign left_sub  = left_q - 8'(asize_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign stat_o.pkt_open  = open_q;
  assign stat_o.elem_full = elem_full;
  assign stat_o.rd_zero   = (ridx_q == '0);
  assign stat_o.out_free  = out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 8'd0;
      ending_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rwpf_pkg::CFG_HEADER_BYTE: header_q <= cfg_data_i;
        rwpf_pkg::CFG_ENDING_BYTE: ending_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Packet state updates.
  always_comb begin
    open_d  = open_q;
    asize_d = asize_q;
    bidx_d  = bidx_q;
    ridx_d  = ridx_q;
    left_d  = left_q;
    if (cmd_i.load_start) begin
      // A start request abandons any open packet.
      open_d  = !start_bad && (in_data_i.byte_count >= in_data_i.element_size);
      asize_d = start_bad ? '0 : in_data_i.element_size[SW-1:0];
      bidx_d  = '0;
      left_d  = in_data_i.byte_count;
    end else if (cmd_i.store_byte) begin
      if (elem_full) begin
        bidx_d = '0;
        ridx_d = IW'(asize_q - SW'(1));
        left_d = left_sub;
        open_d = left_sub >= 8'(asize_q);
      end else begin
        bidx_d = bidx_q + IW'(1);
      end
    end else if (cmd_i.emit && cmd_i.sel == rwpf_pkg::SEL_PAYLOAD) begin
      ridx_d = ridx_q - IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      asize_q <= '0;
      bidx_q  <= '0;
      ridx_q  <= '0;
      left_q  <= 8'd0;
    end else begin
      open_q  <= open_d;
      asize_q <= asize_d;
      bidx_q  <= bidx_d;
      ridx_q  <= ridx_d;
      left_q  <= left_d;
    end
  end

  // Start fields kept for the header bytes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      addr_q  <= in_data_i.reg_addr;
      count_q <= in_data_i.byte_count;
      size_q  <= in_data_i.element_size;
      err_q   <= start_bad;
    end
  end

  // Element buffer, filled in arrival order.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      buffer_q[bidx_q] <= in_data_i.data_byte;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, selected by the controller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.end_of_run    <= cmd_i.last;
      out_q.end_of_packet <= (cmd_i.sel == rwpf_pkg::SEL_ENDING);
      out_q.size_error    <= err_q && (cmd_i.sel != rwpf_pkg::SEL_PAYLOAD);
      case (cmd_i.sel)
        rwpf_pkg::SEL_HEADER:  out_q.tx_byte <= header_q;
        rwpf_pkg::SEL_ADDR:    out_q.tx_byte <= addr_q;
        rwpf_pkg::SEL_COUNT:   out_q.tx_byte <= count_q;
        rwpf_pkg::SEL_SIZE:    out_q.tx_byte <= size_q;
        rwpf_pkg::SEL_PAYLOAD: out_q.tx_byte <= buffer_q[ridx_q];
        default:               out_q.tx_byte <= ending_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Payload bytes are only stored into an open packet.
  a_store_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_byte |-> open_q)
    else $error("payload byte stored with no open packet");

  // An open packet always has a valid size and at least one element to come.
  a_open_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (asize_q != '0) && (left_q >= 8'(asize_q)))
    else $error("open packet with inconsistent element bookkeeping");

endmodule

/* design/register_write_packet_framer.sv */
// Register-write packet framer.
// Input channel (in_valid_i / in_ready_o / in_data_i): a start request
// (mode 0) opens a packet and yields header, address, count and size bytes,
// plus the ending byte at once when the size is bad or no whole element fits.
// A data request (mode 1) stores one payload byte; the request that completes
// an element yields its bytes last-received first, then the ending byte after
// the final element. Data with no open packet is dropped.
// Output channel (out_valid_o / out_ready_i / out_data_o): one byte per
// transfer, end_of_run marks the last byte caused by an input request.
// Configuration channel (cfg_*): header and ending bytes, always ready.
// Timing: after a start is accepted the controller state and then the output
// register are updated before the first byte appears; the controller emits one
// byte per cycle into the output register while it is free, and the input is
// ready again as soon as the last byte is loaded. A data byte that does not
// finish an element leaves the controller idle and the input ready.
// When the receiver stalls, the controller holds in its state until the
// output register frees up. Reset closes any packet and clears both
// configuration bytes; no clearing pass is needed.
module register_write_packet_framer #(
  parameter int MAX_ELEMENT_BYTES = rwpf_pkg::MAX_ELEMENT_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rwpf_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rwpf_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rwpf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  rwpf_pkg::ctrl_cmd_t cmd;
  rwpf_pkg::dp_stat_t  stat;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  rwpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rwpf_datapath #(
    .MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
